// ===== rtl/wla_pkg.sv =====
// wla_pkg: shared types and constants for the windowed level alarm
// sensor offset, scaling table entries and configuration register indexes
// no dependencies
package wla_pkg;

	localparam int SENSOR_OFFSET     = 51;
	localparam int FULL_SCALE_TENTHS = 100;
	localparam int SpanCounts        = (SENSOR_OFFSET < 255) ? (255 - SENSOR_OFFSET) : 1;
	localparam int TenthsMax         = (FULL_SCALE_TENTHS > 127) ? 127 : FULL_SCALE_TENTHS;

	localparam int SAMPLE_W = 8;
	localparam int TENTHS_W = 7;
	localparam int CFG_W    = 8;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HIGH_LEVEL    = 3'd0,
		CFG_LOW_LEVEL     = 3'd1,
		CFG_WINDOW_LENGTH = 3'd2,
		CFG_SET_COUNT     = 3'd3,
		CFG_CLEAR_COUNT   = 3'd4
	} cfg_index_t;

	localparam logic [CFG_W-1:0] RST_HIGH_LEVEL    = 8'd191;
	localparam logic [CFG_W-1:0] RST_LOW_LEVEL     = 8'd111;
	localparam logic [CFG_W-1:0] RST_WINDOW_LENGTH = 8'd30;
	localparam logic [CFG_W-1:0] RST_SET_COUNT     = 8'd21;
	localparam logic [CFG_W-1:0] RST_CLEAR_COUNT   = 8'd9;

	// output word bit positions
	localparam int OUT_HIGH_BIT   = 0;
	localparam int OUT_LOW_BIT    = 1;
	localparam int OUT_TENTHS_LSB = 2;
	localparam int OUT_USED_W     = OUT_TENTHS_LSB + TENTHS_W;
	localparam int OUT_W          = 16;

	typedef logic [TENTHS_W-1:0] tenths_t;

	// scaling table entry, evaluated at elaboration for each sample code
	function automatic tenths_t scale_entry(input int code);
		int v;
		v = 0;
		if (code >= SENSOR_OFFSET) begin
			if (SENSOR_OFFSET >= 255)
				v = FULL_SCALE_TENTHS;
			else
				v = ((code - SENSOR_OFFSET) * FULL_SCALE_TENTHS) / SpanCounts;
		end
		if (v > 127)
			v = 127;
		return tenths_t'(v);
	endfunction

endpackage

// ===== rtl/windowed_level_alarm.sv =====
// windowed_level_alarm: top level, sample window counting with hysteresis alarms
// depends on wla_pkg
//
// One result word per sample word, one word per clock sustained while the
// output is not stalled: a sample is captured in an input register, and from
// there the window counters, alarm flags and the scaled pressure (a constant
// table lookup) are computed and land in the output register when the output
// can take a word. While the output is stalled the input register takes one
// more word and then s_tready stays low until the output word moves.
// m_tlast marks the word that closed a window and m_tuser flags a sensor error.
// Configuration writes are meant for idle periods; window_length of zero
// means 256 samples, and lowering it mid-window closes the window on the
// next sample that reaches or passes the new length.
module windowed_level_alarm
	import wla_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [SAMPLE_W-1:0]  s_tdata,   // [7:0] sample
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [OUT_W-1:0]     m_tdata,   // [0] high_alarm, [1] low_alarm,
	                                        // [8:2] pressure_tenths, [15:9] zero
	output logic                 m_tlast,   // window_closed
	output logic                 m_tuser,   // [0] sensor_error
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic [CFG_W-1:0] high_level_q, low_level_q, window_length_q, set_count_q, clear_count_q;
	logic [7:0] above_count_q, below_count_q, samples_in_window_q;
	logic       high_flag_q, low_flag_q;

	logic                valid_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic                advance;

	tenths_t scale_lut [256];

	logic       is_high, is_low, closed, sensor_error, high_next, low_next;
	logic [7:0] above_inc, below_inc;
	logic [8:0] taken, len;
	tenths_t    tenths;

	for (genvar i = 0; i < 256; i++) begin : g_lut
		assign scale_lut[i] = scale_entry(i);
	end

	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_comb begin
		is_high = sample_s1 > high_level_q;
		is_low  = !is_high && (sample_s1 < low_level_q);
		above_inc = (is_high && above_count_q != 8'hff) ? above_count_q + 8'd1 : above_count_q;
		below_inc = (is_low && below_count_q != 8'hff) ? below_count_q + 8'd1 : below_count_q;
		taken  = {1'b0, samples_in_window_q} + 9'd1;
		len    = (window_length_q == '0) ? 9'd256 : {1'b0, window_length_q};
		closed = taken >= len;
		if (above_inc > set_count_q)
			high_next = 1'b1;
		else if (above_inc < clear_count_q)
			high_next = 1'b0;
		else
			high_next = high_flag_q;
		if (below_inc > set_count_q)
			low_next = 1'b1;
		else if (below_inc < clear_count_q)
			low_next = 1'b0;
		else
			low_next = low_flag_q;
		if (!closed) begin
			high_next = high_flag_q;
			low_next  = low_flag_q;
		end
		sensor_error = {24'd0, sample_s1} < SENSOR_OFFSET;
		tenths = sensor_error ? '0 : scale_lut[sample_s1];
	end

	// control state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_level_q        <= RST_HIGH_LEVEL;
			low_level_q         <= RST_LOW_LEVEL;
			window_length_q     <= RST_WINDOW_LENGTH;
			set_count_q         <= RST_SET_COUNT;
			clear_count_q       <= RST_CLEAR_COUNT;
			above_count_q       <= '0;
			below_count_q       <= '0;
			samples_in_window_q <= '0;
			high_flag_q         <= 1'b0;
			low_flag_q          <= 1'b0;
			valid_s1            <= 1'b0;
			m_tvalid            <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_HIGH_LEVEL:    high_level_q    <= cfg_data;
					CFG_LOW_LEVEL:     low_level_q     <= cfg_data;
					CFG_WINDOW_LENGTH: window_length_q <= cfg_data;
					CFG_SET_COUNT:     set_count_q     <= cfg_data;
					CFG_CLEAR_COUNT:   clear_count_q   <= cfg_data;
					default: ;
				endcase
			end
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (advance) begin
				m_tvalid    <= 1'b1;
				high_flag_q <= high_next;
				low_flag_q  <= low_next;
				if (closed) begin
					above_count_q       <= '0;
					below_count_q       <= '0;
					samples_in_window_q <= '0;
				end else begin
					above_count_q       <= above_inc;
					below_count_q       <= below_inc;
					samples_in_window_q <= taken[7:0];
				end
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid)
			sample_s1 <= s_tdata;
		if (advance) begin
			m_tdata <= {(OUT_W - OUT_USED_W)'(0), tenths, low_next, high_next};
			m_tlast <= closed;
			m_tuser <= sensor_error;
		end
	end

endmodule

// ===== rtl/wla_checker.sv =====
// wla_checker: port-level checks for windowed_level_alarm, bound to the top level
// depends on wla_pkg and windowed_level_alarm
module wla_checker
	import wla_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata,
	input logic             m_tlast,
	input logic             m_tuser
);

	// stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable({m_tuser, m_tlast, m_tdata}))
		else $error("output word changed while stalled");

	// empty output stage never blocks the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output stage");

	// sensor error forces zero pressure
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[OUT_USED_W-1:OUT_TENTHS_LSB] == '0)
		else $error("pressure nonzero on sensor error");

	// scaled pressure within full scale
	a_tenths_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> {25'd0, m_tdata[OUT_USED_W-1:OUT_TENTHS_LSB]} <= TenthsMax)
		else $error("pressure above full scale");

endmodule

bind windowed_level_alarm wla_checker u_wla_checker (.*);

// ===== sim/tb_top.sv =====
// tb_top: self-checking bench for windowed_level_alarm, stream in and out
// predicts each result word from its own copy of the counters and registers
// depends on wla_pkg and the windowed_level_alarm top level
module tb_top;
	import wla_pkg::*;

	localparam int HALF_PERIOD = 5;
	localparam int CYCLE_LIMIT = 200000;
	localparam int MAX_REPORTS = 10;
	localparam int DRAIN_CYCLES = 10;

	typedef struct packed {
		logic    high_alarm;
		logic    low_alarm;
		logic    window_closed;
		tenths_t pressure_tenths;
		logic    sensor_error;
	} alarm_word_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [SAMPLE_W-1:0]  s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [OUT_W-1:0]     m_tdata;
	logic                 m_tlast;
	logic                 m_tuser;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	// local copy of the block's registers and window state
	logic [7:0] lvl_high = RST_HIGH_LEVEL;
	logic [7:0] lvl_low = RST_LOW_LEVEL;
	logic [7:0] win_len = RST_WINDOW_LENGTH;
	logic [7:0] set_cnt = RST_SET_COUNT;
	logic [7:0] clr_cnt = RST_CLEAR_COUNT;
	logic [7:0] above_cnt = '0;
	logic [7:0] below_cnt = '0;
	logic [7:0] window_fill = '0;
	logic       high_flag_m = 1'b0;
	logic       low_flag_m = 1'b0;

	alarm_word_t pending_words[$];
	int error_count = 0;
	int samples_sent = 0;
	int words_checked = 0;
	int windows_closed = 0;
	int cycle_count = 0;
	bit src_idle_on = 1'b1;
	bit sink_stall_on = 1'b1;
	int sink_stall_left = 0;

	windowed_level_alarm uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // [7:0] sample
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),   // [0] high, [1] low, [8:2] tenths
		.m_tlast   (m_tlast),   // window closed
		.m_tuser   (m_tuser),   // [0] sensor error
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still pending", cycle_count,
				pending_words.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic logic judge_flag(logic flag, logic [7:0] cnt);
		if (cnt > set_cnt)
			return 1'b1;
		if (cnt < clr_cnt)
			return 1'b0;
		return flag;
	endfunction

	function automatic tenths_t scaled_pressure(logic [7:0] s);
		int v;
		if (SENSOR_OFFSET >= 255)
			v = FULL_SCALE_TENTHS;
		else
			v = ((int'(s) - SENSOR_OFFSET) * FULL_SCALE_TENTHS) / (255 - SENSOR_OFFSET);
		if (v > 127)
			v = 127;
		return tenths_t'(v);
	endfunction

	function automatic alarm_word_t predict_alarm_word(logic [7:0] s);
		alarm_word_t w;
		int span;
		int taken;
		span = (win_len == 8'd0) ? 256 : int'(win_len);
		if (s > lvl_high) begin
			if (above_cnt != 8'hff)
				above_cnt = above_cnt + 8'd1;
		end else if (s < lvl_low) begin
			if (below_cnt != 8'hff)
				below_cnt = below_cnt + 8'd1;
		end
		taken = int'(window_fill) + 1;
		w.window_closed = 1'b0;
		if (taken >= span) begin
			high_flag_m = judge_flag(high_flag_m, above_cnt);
			low_flag_m = judge_flag(low_flag_m, below_cnt);
			above_cnt = '0;
			below_cnt = '0;
			window_fill = '0;
			w.window_closed = 1'b1;
		end else begin
			window_fill = 8'(taken);
		end
		if (int'(s) < SENSOR_OFFSET) begin
			w.sensor_error = 1'b1;
			w.pressure_tenths = '0;
		end else begin
			w.sensor_error = 1'b0;
			w.pressure_tenths = scaled_pressure(s);
		end
		w.high_alarm = high_flag_m;
		w.low_alarm = low_flag_m;
		return w;
	endfunction

	task automatic log_mismatch(input string msg);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("ERROR at cycle %0d: %s", cycle_count, msg);
	endtask

	task automatic check_alarm_word(input logic [OUT_W-1:0] d, input logic last,
			input logic user);
		alarm_word_t got;
		alarm_word_t want;
		got.high_alarm = d[OUT_HIGH_BIT];
		got.low_alarm = d[OUT_LOW_BIT];
		got.window_closed = last;
		got.pressure_tenths = d[OUT_TENTHS_LSB +: TENTHS_W];
		got.sensor_error = user;
		if (pending_words.size() == 0) begin
			log_mismatch($sformatf("result word %h with no sample pending", d));
			return;
		end
		want = pending_words.pop_front();
		words_checked++;
		if (want.window_closed)
			windows_closed++;
		if (got.high_alarm !== want.high_alarm || got.low_alarm !== want.low_alarm ||
				got.window_closed !== want.window_closed ||
				got.pressure_tenths !== want.pressure_tenths ||
				got.sensor_error !== want.sensor_error)
			log_mismatch($sformatf({"word %0d: exp high %b low %b closed %b tenths %0d err %b,",
				" got high %b low %b closed %b tenths %0d err %b"}, words_checked,
				want.high_alarm, want.low_alarm, want.window_closed, want.pressure_tenths,
				want.sensor_error, got.high_alarm, got.low_alarm, got.window_closed,
				got.pressure_tenths, got.sensor_error));
	endtask

	// result side: check accepted words, stall in random bursts
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				check_alarm_word(m_tdata, m_tlast, m_tuser);
			if (sink_stall_left > 0) begin
				m_tready <= 1'b0;
				sink_stall_left = sink_stall_left - 1;
			end else if (sink_stall_on && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				sink_stall_left = $urandom_range(1, 18) - 1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic send_sample(input logic [SAMPLE_W-1:0] s);
		int gap;
		if (src_idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 18);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= s;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_words.push_back(predict_alarm_word(s));
		samples_sent++;
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [7:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_HIGH_LEVEL:    lvl_high = v;
			CFG_LOW_LEVEL:     lvl_low = v;
			CFG_WINDOW_LENGTH: win_len = v;
			CFG_SET_COUNT:     set_cnt = v;
			CFG_CLEAR_COUNT:   clr_cnt = v;
			default: ;
		endcase
	endtask

	task automatic apply_settings(input int hi, input int lo, input int win, input int setc,
			input int clrc);
		wait_idle();
		write_reg(CFG_HIGH_LEVEL, 8'(hi));
		write_reg(CFG_LOW_LEVEL, 8'(lo));
		write_reg(CFG_WINDOW_LENGTH, 8'(win));
		write_reg(CFG_SET_COUNT, 8'(setc));
		write_reg(CFG_CLEAR_COUNT, 8'(clrc));
	endtask

	function automatic int pick_setting(int lo_lim, int hi_lim);
		case ($urandom_range(0, 3))
			0: return lo_lim;
			1: return hi_lim;
			default: return $urandom_range(lo_lim, hi_lim);
		endcase
	endfunction

	function automatic logic [7:0] above_level(int lvl);
		if (lvl >= 255)
			return 8'd255;
		return 8'($urandom_range(lvl + 1, 255));
	endfunction

	function automatic logic [7:0] below_level(int lvl);
		if (lvl <= 0)
			return 8'd0;
		return 8'($urandom_range(0, lvl - 1));
	endfunction

	function automatic logic [7:0] mixed_sample(int hi, int lo, int p_hi, int p_lo);
		int r;
		r = $urandom_range(0, 99);
		if (r < p_hi)
			return above_level(hi);
		if (r < p_hi + p_lo)
			return below_level(lo);
		return 8'($urandom_range(0, 255));
	endfunction

	// reset settings, scaling at the offset, level edges and full scale
	task automatic test_scaling_extremes();
		logic [7:0] vals[12] = '{8'd0, 8'd50, 8'd51, 8'd52, 8'd110, 8'd111, 8'd112,
			8'd191, 8'd192, 8'd128, 8'd254, 8'd255};
		foreach (vals[i])
			send_sample(vals[i]);
	endtask

	// high level below low level: a sample between counts as high only
	task automatic test_overlap_levels();
		apply_settings(100, 200, 3, 1, 1);
		repeat (3) send_sample(8'd150);
		repeat (3) send_sample(8'd0);
	endtask

	// set count 0 and clear count 255: set wins over clear
	task automatic test_set_beats_clear();
		apply_settings(100, 200, 1, 0, 255);
		send_sample(8'd255);
		send_sample(8'd150);
		send_sample(8'd0);
		send_sample(8'd100);
	endtask

	// shrink the window below the samples already taken
	task automatic test_window_shrink();
		apply_settings(RST_HIGH_LEVEL, RST_LOW_LEVEL, 200, 2, 1);
		repeat (4) send_sample(8'($urandom_range(0, 255)));
		wait_idle();
		write_reg(CFG_WINDOW_LENGTH, 8'd3);
		repeat (2) send_sample(8'($urandom_range(0, 255)));
	endtask

	// window length zero means 256 samples; both counts saturate
	task automatic test_long_window();
		int hi;
		int lo;
		hi = $urandom_range(0, 60);
		apply_settings(hi, RST_LOW_LEVEL, 0, 254, 1);
		repeat (256) send_sample(above_level(hi));
		lo = $urandom_range(200, 255);
		apply_settings(255, lo, 0, 254, 1);
		repeat (256) send_sample(below_level(lo));
	endtask

	task automatic test_random_settings();
		int hi;
		int lo;
		int win;
		int p_hi;
		int p_lo;
		int span;
		for (int phase = 0; phase < 6; phase++) begin
			hi = pick_setting(0, 255);
			lo = pick_setting(0, 255);
			win = ($urandom_range(0, 4) == 0) ? pick_setting(0, 255) : $urandom_range(1, 12);
			span = (win == 0) ? 255 : win;
			apply_settings(hi, lo, win,
				($urandom_range(0, 3) == 0) ? pick_setting(0, 255) : $urandom_range(0, span),
				($urandom_range(0, 3) == 0) ? pick_setting(0, 255) : $urandom_range(0, span));
			p_hi = $urandom_range(0, 100);
			p_lo = $urandom_range(0, 100 - p_hi);
			repeat (40) send_sample(mixed_sample(hi, lo, p_hi, p_lo));
		end
	endtask

	// no idling on either side
	task automatic test_back_to_back();
		int hi;
		int lo;
		int win;
		hi = $urandom_range(120, 220);
		lo = $urandom_range(40, 120);
		win = $urandom_range(2, 10);
		apply_settings(hi, lo, win, $urandom_range(0, win), $urandom_range(0, win));
		src_idle_on = 1'b0;
		sink_stall_on = 1'b0;
		repeat (80) send_sample(mixed_sample(hi, lo, 35, 35));
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_scaling_extremes();
		test_overlap_levels();
		test_set_beats_clear();
		test_window_shrink();
		test_long_window();
		test_random_settings();
		test_back_to_back();
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("run covered %0d samples, %0d result words checked, %0d window closures",
			samples_sent, words_checked, windows_closed);
		$display("settings swept: level overlap, set over clear, window shrink and 256");
		if (error_count == 0 && pending_words.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/wla_pkg.sv
rtl/windowed_level_alarm.sv
rtl/wla_checker.sv
sim/tb_top.sv
